@@ src/qdt_pkg.sv @@
// Package for the quoted delimiter tokenizer: result kinds, special characters,
// register indexes and the result beat type.
// Used by every module in src; depends on nothing.
package qdt_pkg;

  // Special characters.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // Configuration register indexes.
  localparam logic [2:0] REG_DELIM_0 = 3'd0;
  localparam logic [2:0] REG_DELIM_1 = 3'd1;
  localparam logic [2:0] REG_DELIM_2 = 3'd2;
  localparam logic [2:0] REG_DELIM_3 = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;

  // Number of delimiter registers the register map provides.
  localparam int unsigned MAX_DELIM_REGS = 4;
  // Most result beats one character can cause.
  localparam int unsigned MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic [7:0] ld;
    logic [7:0] rd;
    logic       last;
  } qdt_result_t;

  // Builds one result beat with last cleared.
  function automatic qdt_result_t make_result(kind_t k, logic [7:0] c,
                                               logic [7:0] l, logic [7:0] r);
    qdt_result_t res;
    res.kind = k;
    res.chr  = c;
    res.ld   = l;
    res.rd   = r;
    res.last = 1'b0;
    return res;
  endfunction

endpackage

@@ src/quoted_delimiter_tokenizer.sv @@
// Quoted delimiter tokenizer top level. An input beat passes through the input
// register, then the result buffer, before its first result beat leaves.
// Throughput: one input beat per cycle while each character yields one result and
// out_tready stays high; a character that yields n results holds the single output port until all n have left.
// Reset: synchronous active low; clears tokenizer state and loads default delimiters.
// Depends on qdt_pkg, qdt_core and qdt_out_buf.
module quoted_delimiter_tokenizer import qdt_pkg::*; #(
  parameter int unsigned NUM_DELIMS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // end_of_text
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_char, [15:8] left_delim, [23:16] right_delim
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last
  // Configuration port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned NREG =
    (NUM_DELIMS < MAX_DELIM_REGS) ? NUM_DELIMS : MAX_DELIM_REGS;

  logic [7:0]  delim_r [NREG];
  logic [2:0]  count_r;
  logic        in_vld_r;
  logic [7:0]  ch_r;
  logic        eot_r;
  logic        move;
  logic        buf_free;
  qdt_result_t res [MAX_RESULTS];
  logic [1:0]  res_cnt;
  qdt_result_t head;

  // Configuration registers; indexes beyond the map are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        delim_r[i] <= (i == 0) ? CH_SPACE : CH_NUL;
      end
      count_r <= 3'd1;
    end else if (cfg_we) begin
      for (int i = 0; i < NREG; i++) begin
        if (cfg_addr == 3'(i)) begin
          delim_r[i] <= cfg_wdata;
        end
      end
      if (cfg_addr == REG_COUNT) begin
        count_r <= cfg_wdata[2:0];
      end
    end
  end

  // Input register: takes a beat whenever it is empty or its beat moves on.
  assign move      = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r  <= in_tdata;
      eot_r <= in_tlast;
    end
  end

  qdt_core #(
    .NREG (NREG)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (move),
    .ch          (ch_r),
    .eot         (eot_r),
    .delims      (delim_r),
    .delim_count (count_r),
    .res         (res),
    .res_cnt     (res_cnt)
  );

  qdt_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (move),
    .res        (res),
    .res_cnt    (res_cnt),
    .free       (buf_free),
    .head_valid (out_tvalid),
    .head       (head),
    .head_ready (out_tready)
  );

  // Result beat packing.
  assign out_tdata = {head.rd, head.ld, head.chr};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ src/qdt_core.sv @@
// Per-character tokenizer step: quote, escape and left-delimiter state plus
// the logic that turns one character into up to three result beats.
// Depends on qdt_pkg.
module qdt_core import qdt_pkg::*; #(
  parameter int unsigned NREG = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  ch,
  input  logic        eot,
  input  logic [7:0]  delims [NREG],
  input  logic [2:0]  delim_count,
  output qdt_result_t res [MAX_RESULTS],
  output logic [1:0]  res_cnt
);

  logic       inq_r, inq_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] ld_r,  ld_nxt;
  logic       is_d;

  // Delimiter match against the active registers; a count of zero acts as one.
  always_comb begin
    is_d = 1'b0;
    for (int i = 0; i < NREG; i++) begin
      if (((i == 0) || (int'(delim_count) > i)) && (delims[i] == ch)) begin
        is_d = 1'b1;
      end
    end
  end

  // Result list and next state for one character.
  always_comb begin
    logic [1:0] idx;
    res     = '{default: '0};
    idx     = 2'd0;
    inq_nxt = inq_r;
    esc_nxt = esc_r;
    ld_nxt  = ld_r;

    if (esc_r && is_d) begin
      // An escaped delimiter becomes a plain token character.
      res[idx] = make_result(KIND_CHAR, ch, CH_NUL, CH_NUL);
      idx      = idx + 2'd1;
      esc_nxt  = 1'b0;
    end else begin
      if (esc_r) begin
        res[idx] = make_result(KIND_CHAR, CH_BACKSLASH, CH_NUL, CH_NUL);
        idx      = idx + 2'd1;
        esc_nxt  = 1'b0;
      end
      if (ch == CH_BACKSLASH) begin
        esc_nxt = 1'b1;
      end else if (ch == CH_QUOTE) begin
        inq_nxt  = !inq_r;
        res[idx] = make_result(KIND_CHAR, ch, CH_NUL, CH_NUL);
        idx      = idx + 2'd1;
      end else if (is_d && !inq_r) begin
        res[idx] = make_result(KIND_END, CH_NUL, ld_r, ch);
        idx      = idx + 2'd1;
        ld_nxt   = ch;
      end else begin
        res[idx] = make_result(KIND_CHAR, ch, CH_NUL, CH_NUL);
        idx      = idx + 2'd1;
      end
    end

    // End of text flushes a held backslash and closes the final token, or reports an error inside an open quote.
    if (eot) begin
      if (esc_nxt) begin
        res[idx] = make_result(KIND_CHAR, CH_BACKSLASH, CH_NUL, CH_NUL);
        idx      = idx + 2'd1;
      end
      if (inq_nxt) begin
        res[idx] = make_result(KIND_ERR, CH_NUL, CH_NUL, CH_NUL);
      end else begin
        res[idx] = make_result(KIND_END, CH_NUL, ld_nxt, CH_NUL);
      end
      idx     = idx + 2'd1;
      inq_nxt = 1'b0;
      esc_nxt = 1'b0;
      ld_nxt  = CH_NUL;
    end

    // Mark the final beat of this character.
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = ((2'(i) + 2'd1) == idx);
    end
    res_cnt = idx;
  end

  // Tokenizer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r <= 1'b0;
      esc_r <= 1'b0;
      ld_r  <= CH_NUL;
    end else if (step) begin
      inq_r <= inq_nxt;
      esc_r <= esc_nxt;
      ld_r  <= ld_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A text end always leaves the state as after reset.
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && eot |=> !inq_r && !esc_r && (ld_r == CH_NUL))
    else $error("state not cleared after end of text");

  // A text end always produces at least the closing beat.
  a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
    step && eot |-> res_cnt != 2'd0)
    else $error("end of text produced no result");

  // Only a backslash can produce no result.
  a_silent_bs: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res_cnt == 2'd0) |-> (ch == CH_BACKSLASH) && !eot)
    else $error("character produced no result");
`endif

endmodule

@@ src/qdt_out_buf.sv @@
// Result buffer: holds the beats of one character and hands them out one per
// cycle while head_ready is high, head first. Depends on qdt_pkg.
module qdt_out_buf import qdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  qdt_result_t res [MAX_RESULTS],
  input  logic [1:0]  res_cnt,
  output logic        free,
  output logic        head_valid,
  output qdt_result_t head,
  input  logic        head_ready
);

  qdt_result_t buf_r [MAX_RESULTS];
  qdt_result_t buf_nxt [MAX_RESULTS];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = buf_r[0];
  assign pop        = head_valid && head_ready;
  // The buffer can take a new set when it is empty or its last beat leaves now.
  assign free       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && head_ready);

  // Load a fresh set, or shift down by one beat on a pop.
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = res;
      cnt_nxt = res_cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The head carries last exactly when it is the final beat held.
  a_last_head: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (head.last == (cnt_r == 2'd1)))
    else $error("last flag out of step with buffer count");

  // A stalled head keeps the buffer count unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && !head_ready |=> $stable(cnt_r))
    else $error("buffer changed while head stalled");

  // Never load over beats that are still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("buffer loaded while not free");
`endif

endmodule
